>>> rtl/zigzag_delta_vbyte16_encoder_macros.svh
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder assertion macros
// Shared forms for the concurrent checks on the encoder ports.
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_DELTA_VBYTE16_ENCODER_MACROS_SVH
`define ZIGZAG_DELTA_VBYTE16_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ZDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zde port check failed");

// Next-cycle implication, disabled while reset is held
`define ZDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zde port check failed");

`endif

>>> rtl/zde_pkg.sv
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder package
// Widths, register indexes, the job record and the back-end step codes.
// ----------------------------------------------------------------------------
package zde_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 34;
  localparam int COUNT_W    = 32;
  localparam int KEY_LEN_W  = 30;
  localparam int KOFF_W     = 29;
  localparam int KEY_POS_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PREVIOUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT     = 2'd1;

  // One classified sample, handed from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] code;
    logic                two;
    logic                key_due;
    logic [BYTE_W-1:0]   key_byte;
    logic [OFFSET_W-1:0] base;
    logic [KOFF_W-1:0]   koff;
    logic                is_final;
  } zde_job_t;

  typedef enum logic [1:0] {
    STEP_LO,
    STEP_HI,
    STEP_KEY
  } zde_step_t;

endpackage

>>> rtl/zde_front.sv
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder front end
// Holds configuration and stream state, codes each sample and builds a job.
// ----------------------------------------------------------------------------
module zde_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [zde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zde_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [zde_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         push_valid,
  input  logic                         push_ready,
  output zde_pkg::zde_job_t            push_job
);
  import zde_pkg::*;

  logic [SAMPLE_W-1:0]  init_prev_r;
  logic [COUNT_W-1:0]   count_m1_r;
  logic [KEY_LEN_W-1:0] key_len_r;
  logic [SAMPLE_W-1:0]  prev_r;
  logic [BYTE_W-1:0]    key_acc_r;
  logic [KEY_POS_W-1:0] key_pos_r;
  logic [COUNT_W-1:0]   seen_r;
  logic [OFFSET_W-1:0]  data_off_r;

  logic [SAMPLE_W-1:0]  prev;
  logic [SAMPLE_W-1:0]  delta;
  logic [SAMPLE_W-1:0]  code;
  logic                 two;
  logic                 is_final;
  logic                 key_due;
  logic [BYTE_W-1:0]    key_byte;
  logic                 accept;
  logic [COUNT_W:0]     len_sum;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    prev     = (seen_r == '0) ? init_prev_r : prev_r;
    delta    = in_sample - prev;
    code     = {delta[SAMPLE_W-2:0], 1'b0} ^ {SAMPLE_W{delta[SAMPLE_W-1]}};
    two      = |code[SAMPLE_W-1:BYTE_W];
    is_final = seen_r >= count_m1_r;
    key_due  = is_final || (key_pos_r == {KEY_POS_W{1'b1}});
    key_byte = key_acc_r | (BYTE_W'(two) << key_pos_r);
    len_sum  = {1'b0, cfg_data} + (COUNT_W+1)'(7);
  end

  always_comb begin
    push_job.code     = code;
    push_job.two      = two;
    push_job.key_due  = key_due;
    push_job.key_byte = key_byte;
    push_job.base     = OFFSET_W'(key_len_r) + data_off_r;
    push_job.koff     = seen_r[COUNT_W-1:KEY_POS_W];
    push_job.is_final = is_final;
  end

  // Configuration registers; a zero count behaves as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_prev_r <= '0;
      count_m1_r  <= '0;
      key_len_r   <= KEY_LEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_INITIAL_PREVIOUS: init_prev_r <= cfg_data[SAMPLE_W-1:0];
        CFG_SAMPLE_COUNT: begin
          if (cfg_data == '0) begin
            count_m1_r <= '0;
            key_len_r  <= KEY_LEN_W'(1);
          end else begin
            count_m1_r <= cfg_data - COUNT_W'(1);
            key_len_r  <= len_sum[COUNT_W:KEY_POS_W];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      key_acc_r  <= '0;
      key_pos_r  <= '0;
      seen_r     <= '0;
      data_off_r <= '0;
    end else if (accept) begin
      if (key_due) begin
        key_acc_r <= '0;
        key_pos_r <= '0;
      end else begin
        key_acc_r <= key_byte;
        key_pos_r <= key_pos_r + KEY_POS_W'(1);
      end
      if (is_final) begin
        // start a fresh stream
        seen_r     <= '0;
        data_off_r <= '0;
        prev_r     <= init_prev_r;
      end else begin
        seen_r     <= seen_r + COUNT_W'(1);
        data_off_r <= data_off_r + (two ? OFFSET_W'(2) : OFFSET_W'(1));
        prev_r     <= in_sample;
      end
    end
  end

endmodule

>>> rtl/zde_queue.sv
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder job queue
// Small register queue that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
module zde_queue #(
  parameter int DEPTH = zde_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  zde_pkg::zde_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output zde_pkg::zde_job_t pop_job
);
  import zde_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  zde_job_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;
  logic                 push;
  logic                 pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/zde_back.sv
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder back end
// Walks each job through its data and key bytes into the output register.
// ----------------------------------------------------------------------------
module zde_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  zde_pkg::zde_job_t            pop_job,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [zde_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_is_key,
  output logic [zde_pkg::OFFSET_W-1:0] out_byte_offset,
  output logic                         out_run_last,
  output logic                         out_stream_end,
  output logic [zde_pkg::OFFSET_W-1:0] out_total_bytes
);
  import zde_pkg::*;

  zde_job_t            cur_r;
  logic                cur_valid_r;
  logic                cur_valid_nxt;
  zde_step_t           step_r;
  zde_step_t           step_nxt;
  zde_step_t           step_adv;

  logic                out_valid_r;
  logic [BYTE_W-1:0]   byte_r;
  logic                is_key_r;
  logic [OFFSET_W-1:0] off_r;
  logic                last_r;
  logic                end_r;
  logic [OFFSET_W-1:0] total_r;

  logic [BYTE_W-1:0]   byte_c;
  logic                is_key_c;
  logic [OFFSET_W-1:0] off_c;
  logic                last_c;
  logic                end_c;
  logic [OFFSET_W-1:0] total_c;
  logic                done;
  logic                advance;
  logic                pop;

  assign advance   = cur_valid_r && (!out_valid_r || out_ready);
  assign pop       = pop_valid && (!cur_valid_r || (advance && done));
  assign pop_ready = !cur_valid_r || (advance && done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_LO;
      cur_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_comb begin
    byte_c   = cur_r.code[BYTE_W-1:0];
    is_key_c = 1'b0;
    off_c    = cur_r.base;
    last_c   = !cur_r.two && !cur_r.key_due;
    end_c    = 1'b0;
    total_c  = '0;
    done     = !cur_r.two && !cur_r.key_due;
    step_adv = cur_r.two ? STEP_HI : STEP_KEY;
    unique case (step_r)
      STEP_LO: ;
      STEP_HI: begin
        byte_c   = cur_r.code[SAMPLE_W-1:BYTE_W];
        off_c    = cur_r.base + OFFSET_W'(1);
        last_c   = !cur_r.key_due;
        done     = !cur_r.key_due;
        step_adv = STEP_KEY;
      end
      STEP_KEY: begin
        byte_c   = cur_r.key_byte;
        is_key_c = 1'b1;
        off_c    = OFFSET_W'(cur_r.koff);
        last_c   = 1'b1;
        end_c    = cur_r.is_final;
        total_c  = cur_r.is_final ?
                   cur_r.base + (cur_r.two ? OFFSET_W'(2) : OFFSET_W'(1)) : '0;
        done     = 1'b1;
        step_adv = STEP_LO;
      end
      default: ;
    endcase

    step_nxt      = step_r;
    cur_valid_nxt = cur_valid_r;
    if (pop) begin
      step_nxt      = STEP_LO;
      cur_valid_nxt = 1'b1;
    end else if (advance) begin
      step_nxt = step_adv;
      if (done) begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_job;
    end
  end

  // Output register: load a byte when free or being taken, hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r   <= byte_c;
      is_key_r <= is_key_c;
      off_r    <= off_c;
      last_r   <= last_c;
      end_r    <= end_c;
      total_r  <= total_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_is_key      = is_key_r;
  assign out_byte_offset = off_r;
  assign out_run_last    = last_r;
  assign out_stream_end  = end_r;
  assign out_total_bytes = total_r;

endmodule

>>> rtl/zigzag_delta_vbyte16_encoder.sv
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder, top level
//
// Channel  Direction  Handshake            Carries
// in_      in         in_valid/in_ready    in_sample, one 16-bit sample
// out_     out        out_valid/out_ready  one key or data byte with offsets
// cfg_     in         cfg_wr_en            cfg_index, cfg_data register write
//
// A sample yields one or two data bytes and, on every eighth and on the
// final sample, one key byte, sent via the back end's single byte-wide
// output register. The front end takes a sample every cycle while the job
// queue has room; a job goes via the queue, current-job and output registers.
// Synchronous reset; no clearing pass. Either side may stall at any time.
// ----------------------------------------------------------------------------
module zigzag_delta_vbyte16_encoder #(
  parameter int QUEUE_DEPTH = zde_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [zde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zde_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [zde_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [zde_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_is_key,
  output logic [zde_pkg::OFFSET_W-1:0]   out_byte_offset,
  output logic                           out_run_last,
  output logic                           out_stream_end,
  output logic [zde_pkg::OFFSET_W-1:0]   out_total_bytes
);
  import zde_pkg::*;

  logic     push_valid;
  logic     push_ready;
  zde_job_t push_job;
  logic     pop_valid;
  logic     pop_ready;
  zde_job_t pop_job;

  zde_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  zde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  zde_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_job         (pop_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_key      (out_is_key),
    .out_byte_offset (out_byte_offset),
    .out_run_last    (out_run_last),
    .out_stream_end  (out_stream_end),
    .out_total_bytes (out_total_bytes)
  );

endmodule

>>> rtl/zde_checker.sv
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder port checker
// Watches the result channel for hold and field consistency.
// ----------------------------------------------------------------------------
`include "zigzag_delta_vbyte16_encoder_macros.svh"

module zde_port_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [zde_pkg::BYTE_W-1:0]     out_byte,
  input logic                           out_is_key,
  input logic [zde_pkg::OFFSET_W-1:0]   out_byte_offset,
  input logic                           out_run_last,
  input logic                           out_stream_end,
  input logic [zde_pkg::OFFSET_W-1:0]   out_total_bytes
);
  import zde_pkg::*;

  // hold a stalled word
  `ZDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_byte_offset) && $stable(out_is_key))

  `ZDE_ASSERT_NOW(a_end_is_key, clk, rst_n, out_valid && out_stream_end, out_is_key && out_run_last)

  `ZDE_ASSERT_NOW(a_key_closes_run, clk, rst_n, out_valid && out_is_key, out_run_last)

  `ZDE_ASSERT_NOW(a_total_only_at_end, clk, rst_n, out_valid && !out_stream_end, out_total_bytes == '0)

endmodule

bind zigzag_delta_vbyte16_encoder zde_port_checker u_zde_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_is_key      (out_is_key),
  .out_byte_offset (out_byte_offset),
  .out_run_last    (out_run_last),
  .out_stream_end  (out_stream_end),
  .out_total_bytes (out_total_bytes)
);

>>> sim/zde_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder checker
// Watches the register port and both channels, works out the bytes that each
// accepted sample must give, and compares every accepted output word with the
// oldest expected byte. Reports the mismatch count and the bytes outstanding.
// ----------------------------------------------------------------------------
module zde_checker
  import zde_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [BYTE_W-1:0]     out_byte,
  input  logic                  out_is_key,
  input  logic [OFFSET_W-1:0]   out_byte_offset,
  input  logic                  out_run_last,
  input  logic                  out_stream_end,
  input  logic [OFFSET_W-1:0]   out_total_bytes,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [BYTE_W-1:0]   value;
    logic                is_key;
    logic [OFFSET_W-1:0] offset;
    logic                run_last;
    logic                stream_end;
    logic [OFFSET_W-1:0] total;
  } enc_byte_t;

  enc_byte_t expected_bytes[$];
  int        mismatches = 0;

  logic [SAMPLE_W-1:0] start_prev;
  logic [COUNT_W-1:0]  stream_len;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [BYTE_W-1:0]   key_acc;
  logic [2:0]          key_pos;
  logic [COUNT_W-1:0]  seen;
  logic [OFFSET_W-1:0] data_off;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic is_key,
                           input logic [OFFSET_W-1:0] offset, input logic run_last,
                           input logic stream_end, input logic [OFFSET_W-1:0] total);
    enc_byte_t b;
    b.value      = value;
    b.is_key     = is_key;
    b.offset     = offset;
    b.run_last   = run_last;
    b.stream_end = stream_end;
    b.total      = total;
    expected_bytes.push_back(b);
  endtask

  task encode_sample(input logic [SAMPLE_W-1:0] s);
    logic [OFFSET_W-1:0] eff_count;
    logic [OFFSET_W-1:0] key_len;
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] delta;
    logic [SAMPLE_W-1:0] code;
    logic                two;
    logic                ends;
    logic                key_due;
    logic [OFFSET_W-1:0] base;
    logic [OFFSET_W-1:0] ndata;
    eff_count = (stream_len == '0) ? OFFSET_W'(1) : OFFSET_W'(stream_len);
    key_len   = (eff_count + OFFSET_W'(7)) >> 3;
    prev      = (seen == '0) ? start_prev : prev_sample;
    delta     = s - prev;
    code      = {delta[SAMPLE_W-2:0], 1'b0} ^ {SAMPLE_W{delta[SAMPLE_W-1]}};
    two       = (code[SAMPLE_W-1:BYTE_W] != '0);
    ends      = (OFFSET_W'(seen) + OFFSET_W'(1)) >= eff_count;
    key_due   = ends || (key_pos == 3'd7);
    base      = key_len + data_off;
    ndata     = two ? OFFSET_W'(2) : OFFSET_W'(1);

    // data bytes first, low byte first, then the key byte if one is due
    push_byte(code[BYTE_W-1:0], 1'b0, base, !two && !key_due, 1'b0, '0);
    if (two) begin
      push_byte(code[SAMPLE_W-1:BYTE_W], 1'b0, base + OFFSET_W'(1), !key_due, 1'b0, '0);
    end
    key_acc = key_acc | (BYTE_W'(two) << key_pos);
    if (key_due) begin
      push_byte(key_acc, 1'b1, OFFSET_W'(seen) >> 3, 1'b1, ends,
                ends ? base + ndata : '0);
      key_acc = '0;
      key_pos = '0;
    end else begin
      key_pos = key_pos + 3'd1;
    end

    if (ends) begin
      seen        = '0;
      data_off    = '0;
      key_pos     = '0;
      key_acc     = '0;
      prev_sample = start_prev;
    end else begin
      seen        = seen + COUNT_W'(1);
      data_off    = data_off + ndata;
      prev_sample = s;
    end
  endtask

  task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                             input logic [OFFSET_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      start_prev  = '0;
      stream_len  = COUNT_W'(1);
      prev_sample = '0;
      key_acc     = '0;
      key_pos     = '0;
      seen        = '0;
      data_off    = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_INITIAL_PREVIOUS) begin
          start_prev = cfg_data[SAMPLE_W-1:0];
        end else if (cfg_index == CFG_SAMPLE_COUNT) begin
          stream_len = cfg_data[COUNT_W-1:0];
        end
      end
      // check the outgoing word before this edge's sample adds to the store
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual byte %h key %b offset %h",
                   $time, out_byte, out_is_key, out_byte_offset);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", OFFSET_W'(want.value), OFFSET_W'(out_byte));
          check_field("out_is_key", OFFSET_W'(want.is_key), OFFSET_W'(out_is_key));
          check_field("out_byte_offset", want.offset, out_byte_offset);
          check_field("out_run_last", OFFSET_W'(want.run_last), OFFSET_W'(out_run_last));
          check_field("out_stream_end", OFFSET_W'(want.stream_end),
                      OFFSET_W'(out_stream_end));
          check_field("out_total_bytes", want.total, out_total_bytes);
        end
      end
      if (in_valid && in_ready) begin
        encode_sample(in_sample);
      end
    end
    errors  <= mismatches;
    pending <= expected_bytes.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zigzag delta byte encoder testbench
// Drives directed and random sample streams through the encoder under several
// register settings, with random stalls on both channels, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import zde_pkg::*;

  localparam int RANDOM_ITEMS = 388;
  localparam int STUCK_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_is_key;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic                  out_run_last;
  logic                  out_stream_end;
  logic [OFFSET_W-1:0]   out_total_bytes;

  int                  errors;
  int                  pending;
  int                  stuck_cycles = 0;
  int                  items_sent = 0;
  logic                calm = 1'b0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  always #4 clk = ~clk;

  zigzag_delta_vbyte16_encoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_key      (out_is_key),
    .out_byte_offset (out_byte_offset),
    .out_run_last    (out_run_last),
    .out_stream_end  (out_stream_end),
    .out_total_bytes (out_total_bytes)
  );

  zde_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_key      (out_is_key),
    .out_byte_offset (out_byte_offset),
    .out_run_last    (out_run_last),
    .out_stream_end  (out_stream_end),
    .out_total_bytes (out_total_bytes),
    .errors          (errors),
    .pending         (pending)
  );

  // stall the receiver at random unless in a calm stretch
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    last_sample = s;
    items_sent++;
  endtask

  // hold the sender until every expected word is out and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] last);
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      return last + SAMPLE_W'($urandom_range(254)) - SAMPLE_W'(127);
    end else if (r < 75) begin
      return $urandom_range(1) ? last + SAMPLE_W'($urandom_range(1023, 128))
                               : last - SAMPLE_W'($urandom_range(1023, 128));
    end else if (r < 90) begin
      return SAMPLE_W'($urandom_range(65535));
    end
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return last;
      default: return last ^ 16'h8000;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CFG_DATA_W'($urandom_range(8, 1));
    if (r < 55) return CFG_DATA_W'($urandom_range(40, 9));
    if (r < 70) return CFG_DATA_W'(8 * $urandom_range(3, 1));
    if (r < 78) return '0;
    if (r < 86) return CFG_DATA_W'(1);
    if (r < 93) return '1;
    return CFG_DATA_W'($urandom);
  endfunction

  initial begin
    int phase;
    int span;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: every sample is a stream of its own, previous is zero
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0080);
    send_sample(16'h007F);
    send_sample(16'hFF80);
    settle();

    // a count of zero behaves as one
    write_reg(CFG_INITIAL_PREVIOUS, 32'hFFFF_FFFF);
    write_reg(CFG_SAMPLE_COUNT, 32'h0000_0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    settle();

    // writes to unused indexes are dropped
    write_reg(CFG_IDX_W'(2), 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(3), 32'h0000_0005);
    write_reg(CFG_INITIAL_PREVIOUS, 32'h0000_1234);
    write_reg(CFG_SAMPLE_COUNT, 32'd9);
    for (int i = 0; i < 9; i++) begin
      send_sample((i % 3 == 0) ? 16'h1234 ^ SAMPLE_W'(i << 12) : 16'h1234 + SAMPLE_W'(i));
    end
    settle();

    // shrink the count part way through a stream: the next sample ends it
    write_reg(CFG_SAMPLE_COUNT, 32'd20);
    send_sample(16'h0010);
    send_sample(16'hF000);
    send_sample(16'h0011);
    settle();
    write_reg(CFG_SAMPLE_COUNT, 32'd2);
    send_sample(16'h4321);
    settle();

    phase = 0;
    while (items_sent < 22 + RANDOM_ITEMS) begin
      calm = (phase == 3);
      if (phase == 1) begin
        write_reg(CFG_INITIAL_PREVIOUS, 32'h0000_FFFF);
        write_reg(CFG_SAMPLE_COUNT, 32'hFFFF_FFFF);
      end else begin
        if ($urandom_range(99) < 70) begin
          case ($urandom_range(4))
            0: write_reg(CFG_INITIAL_PREVIOUS, '0);
            1: write_reg(CFG_INITIAL_PREVIOUS, 32'h0000_FFFF);
            default: write_reg(CFG_INITIAL_PREVIOUS, $urandom);
          endcase
        end
        if ($urandom_range(99) < 70) begin
          write_reg(CFG_SAMPLE_COUNT, pick_count());
        end
        if ($urandom_range(99) < 10) begin
          write_reg(CFG_IDX_W'($urandom_range(3, 2)), $urandom);
        end
      end
      span = calm ? 60 : $urandom_range(40, 5);
      for (int i = 0; i < span; i++) begin
        send_sample(pick_sample(last_sample));
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
